// File: rtl/ps2mp_pkg.sv
// ----------------------------------------------------------------------------
// ps2mp_pkg
// Shared types and constants of the PS/2 mouse packet-to-pointer block.
// ----------------------------------------------------------------------------
package ps2mp_pkg;

  // mouse protocol bytes and header fields
  localparam logic [7:0] ACK_BYTE   = 8'hFA;
  localparam logic [7:0] HDR_MASK   = 8'hC8;
  localparam logic [7:0] HDR_MATCH  = 8'h08;
  localparam int         HDR_XSIGN  = 4;
  localparam int         HDR_YSIGN  = 5;
  localparam int         BTN_BITS   = 3;
  localparam int         MOVE_X_BITS = 9;
  localparam int         MOVE_Y_BITS = 10;

  // configuration port
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 12;

  localparam logic [CFG_ADDR_BITS-1:0] REG_LIMIT_X = 4'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_LIMIT_Y = 4'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_START_X = 4'd2;
  localparam logic [CFG_ADDR_BITS-1:0] REG_START_Y = 4'd3;

  localparam int RST_LIMIT_X = 304;
  localparam int RST_LIMIT_Y = 184;
  localparam int RST_START_X = 152;
  localparam int RST_START_Y = 78;

  // command handed from the byte front end to the pointer back end
  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_ENABLE,
    CMD_PACKET
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                      kind;
    logic [BTN_BITS-1:0]            buttons;
    logic signed [MOVE_X_BITS-1:0]  move_x;
    logic signed [MOVE_Y_BITS-1:0]  move_y;
  } cmd_t;

endpackage

// File: rtl/ps2mp_front.sv
// ----------------------------------------------------------------------------
// ps2mp_front
// Byte front end: tracks acknowledge and packet phase, assembles packets and
// turns every accepted byte or enable request into a command.
// ----------------------------------------------------------------------------
module ps2mp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_enable,
  input  logic [7:0]        in_byte,
  output logic              push,
  output ps2mp_pkg::cmd_t   push_cmd,
  input  logic              q_full
);

  typedef enum logic [1:0] {
    PH_ACK,
    PH_HEAD,
    PH_X,
    PH_Y
  } phase_t;

  phase_t     phase_r, phase_nxt;
  logic [7:0] header_r, header_nxt;
  logic [7:0] xbyte_r, xbyte_nxt;
  logic       accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign push     = accept;

  always_comb begin
    logic signed [ps2mp_pkg::MOVE_Y_BITS-1:0] raw_y;
    phase_nxt        = phase_r;
    header_nxt       = header_r;
    xbyte_nxt        = xbyte_r;
    raw_y            = '0;
    push_cmd.kind    = ps2mp_pkg::CMD_NONE;
    push_cmd.buttons = header_r[ps2mp_pkg::BTN_BITS-1:0];
    push_cmd.move_x  = {header_r[ps2mp_pkg::HDR_XSIGN], xbyte_r};
    push_cmd.move_y  = '0;
    if (accept) begin
      if (in_enable) begin
        phase_nxt     = PH_ACK;
        push_cmd.kind = ps2mp_pkg::CMD_ENABLE;
      end else begin
        case (phase_r)
          PH_ACK: begin
            if (in_byte == ps2mp_pkg::ACK_BYTE) begin
              phase_nxt = PH_HEAD;
            end
          end
          PH_HEAD: begin
            // drop anything that does not look like a header
            if ((in_byte & ps2mp_pkg::HDR_MASK) == ps2mp_pkg::HDR_MATCH) begin
              header_nxt = in_byte;
              phase_nxt  = PH_X;
            end
          end
          PH_X: begin
            xbyte_nxt = in_byte;
            phase_nxt = PH_Y;
          end
          PH_Y: begin
            // mouse y is up positive, flip to screen direction
            raw_y           = {header_r[ps2mp_pkg::HDR_YSIGN], header_r[ps2mp_pkg::HDR_YSIGN],
                               in_byte};
            push_cmd.kind   = ps2mp_pkg::CMD_PACKET;
            push_cmd.move_y = -raw_y;
            phase_nxt       = PH_HEAD;
          end
          default: begin
            phase_nxt = PH_ACK;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_ACK;
      header_r <= '0;
      xbyte_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      xbyte_r  <= xbyte_nxt;
    end
  end

endmodule

// File: rtl/ps2mp_fifo.sv
// ----------------------------------------------------------------------------
// ps2mp_fifo
// Two-entry command queue between the byte front end and the pointer back end.
// ----------------------------------------------------------------------------
module ps2mp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ps2mp_pkg::cmd_t   push_cmd,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output ps2mp_pkg::cmd_t   pop_cmd
);

  localparam int DEPTH  = 2;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  ps2mp_pkg::cmd_t   mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign valid   = (count_r != '0);
  assign pop_cmd = mem[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: rtl/ps2mp_back.sv
// ----------------------------------------------------------------------------
// ps2mp_back
// Pointer back end: executes commands, keeps the clamped position and the
// last packet, and holds the result in the output register.
// ----------------------------------------------------------------------------
module ps2mp_back #(
  parameter int COORD_BITS = 12
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cmd_valid,
  input  ps2mp_pkg::cmd_t                        cmd,
  output logic                                   pop,
  input  logic [COORD_BITS-1:0]                  limit_x,
  input  logic [COORD_BITS-1:0]                  limit_y,
  input  logic [COORD_BITS-1:0]                  start_x,
  input  logic [COORD_BITS-1:0]                  start_y,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic                                   res_done,
  output logic [ps2mp_pkg::BTN_BITS-1:0]         res_buttons,
  output logic signed [ps2mp_pkg::MOVE_X_BITS-1:0] res_move_x,
  output logic signed [ps2mp_pkg::MOVE_Y_BITS-1:0] res_move_y,
  output logic [COORD_BITS-1:0]                  res_pos_x,
  output logic [COORD_BITS-1:0]                  res_pos_y
);

  localparam int SUM_W = COORD_BITS + 2;

  function automatic logic [COORD_BITS-1:0] clamp_axis(
    input logic [COORD_BITS-1:0]                  pos,
    input logic signed [ps2mp_pkg::MOVE_Y_BITS-1:0] delta,
    input logic [COORD_BITS-1:0]                  lim
  );
    logic signed [SUM_W-1:0] sum;
    logic signed [SUM_W-1:0] lim_s;
    sum   = signed'({2'b00, pos}) + SUM_W'(delta);
    lim_s = signed'({2'b00, lim});
    if (sum < 0) begin
      clamp_axis = '0;
    end else if (sum > lim_s) begin
      clamp_axis = lim;
    end else begin
      clamp_axis = sum[COORD_BITS-1:0];
    end
  endfunction

  logic                                    valid_r, valid_nxt;
  logic                                    done_r, done_nxt;
  logic [ps2mp_pkg::BTN_BITS-1:0]          buttons_r, buttons_nxt;
  logic signed [ps2mp_pkg::MOVE_X_BITS-1:0] move_x_r, move_x_nxt;
  logic signed [ps2mp_pkg::MOVE_Y_BITS-1:0] move_y_r, move_y_nxt;
  logic [COORD_BITS-1:0]                   pos_x_r, pos_x_nxt;
  logic [COORD_BITS-1:0]                   pos_y_r, pos_y_nxt;

  // state only changes when a new result is loaded, so it doubles as payload
  assign pop = cmd_valid && (!valid_r || res_ready);

  always_comb begin
    valid_nxt   = valid_r && !res_ready;
    done_nxt    = done_r;
    buttons_nxt = buttons_r;
    move_x_nxt  = move_x_r;
    move_y_nxt  = move_y_r;
    pos_x_nxt   = pos_x_r;
    pos_y_nxt   = pos_y_r;
    if (pop) begin
      valid_nxt = 1'b1;
      done_nxt  = 1'b0;
      case (cmd.kind)
        ps2mp_pkg::CMD_ENABLE: begin
          // start position is not clamped until the next packet
          pos_x_nxt = start_x;
          pos_y_nxt = start_y;
        end
        ps2mp_pkg::CMD_PACKET: begin
          done_nxt    = 1'b1;
          buttons_nxt = cmd.buttons;
          move_x_nxt  = cmd.move_x;
          move_y_nxt  = cmd.move_y;
          pos_x_nxt   = clamp_axis(pos_x_r, ps2mp_pkg::MOVE_Y_BITS'(cmd.move_x), limit_x);
          pos_y_nxt   = clamp_axis(pos_y_r, cmd.move_y, limit_y);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      done_r    <= 1'b0;
      buttons_r <= '0;
      move_x_r  <= '0;
      move_y_r  <= '0;
      pos_x_r   <= COORD_BITS'(ps2mp_pkg::RST_START_X);
      pos_y_r   <= COORD_BITS'(ps2mp_pkg::RST_START_Y);
    end else begin
      valid_r   <= valid_nxt;
      done_r    <= done_nxt;
      buttons_r <= buttons_nxt;
      move_x_r  <= move_x_nxt;
      move_y_r  <= move_y_nxt;
      pos_x_r   <= pos_x_nxt;
      pos_y_r   <= pos_y_nxt;
    end
  end

  assign res_valid   = valid_r;
  assign res_done    = done_r;
  assign res_buttons = buttons_r;
  assign res_move_x  = move_x_r;
  assign res_move_y  = move_y_r;
  assign res_pos_x   = pos_x_r;
  assign res_pos_y   = pos_y_r;

endmodule

// File: rtl/ps2_mouse_packet_to_pointer.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_to_pointer
// PS/2 mouse three-byte packet decoder with a clamped pointer position.
// ----------------------------------------------------------------------------
// Takes one mouse byte or enable request per cycle while the command queue has
// room, and returns one result per request. Each request passes through the
// command queue and then the output register before its result appears; the
// sustained rate is one request per cycle while out_tready stays high. A
// two-entry queue between the byte front end and the back end plus the
// output register keep input accepted while a result waits downstream.
// After enable the block waits for the 0xFA acknowledge, then decodes packets;
// pos_x/pos_y are clamped to 0..limit on each packet, and enable reloads them
// from start_x/start_y. Write configuration only while no request is in flight.
module ps2_mouse_packet_to_pointer #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: rx_byte[7:0]
  input  logic [7:0]                          in_tdata,
  // in_tuser: operation (0 byte, 1 enable)
  input  logic                                in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: buttons[2:0], move_x[8:0], move_y[9:0], pos_x, pos_y, zero fill
  output logic [(ps2mp_pkg::BTN_BITS + ps2mp_pkg::MOVE_X_BITS + ps2mp_pkg::MOVE_Y_BITS
                 + 2 * COORD_BITS + 7) / 8 * 8 - 1:0] out_tdata,
  // out_tuser: packet_done
  output logic                                out_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [ps2mp_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
  input  logic [ps2mp_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  localparam int PAYLOAD_BITS = ps2mp_pkg::BTN_BITS + ps2mp_pkg::MOVE_X_BITS
                              + ps2mp_pkg::MOVE_Y_BITS + 2 * COORD_BITS;
  localparam int OUT_BITS     = ((PAYLOAD_BITS + 7) / 8) * 8;

  logic [COORD_BITS-1:0] limit_x_r, limit_y_r, start_x_r, start_y_r;

  logic                  push, q_full, q_valid, pop;
  ps2mp_pkg::cmd_t       push_cmd, pop_cmd;

  logic                                    res_done;
  logic [ps2mp_pkg::BTN_BITS-1:0]          res_buttons;
  logic signed [ps2mp_pkg::MOVE_X_BITS-1:0] res_move_x;
  logic signed [ps2mp_pkg::MOVE_Y_BITS-1:0] res_move_y;
  logic [COORD_BITS-1:0]                   res_pos_x, res_pos_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_x_r <= COORD_BITS'(ps2mp_pkg::RST_LIMIT_X);
      limit_y_r <= COORD_BITS'(ps2mp_pkg::RST_LIMIT_Y);
      start_x_r <= COORD_BITS'(ps2mp_pkg::RST_START_X);
      start_y_r <= COORD_BITS'(ps2mp_pkg::RST_START_Y);
    end else if (cfg_valid) begin
      case (cfg_addr)
        ps2mp_pkg::REG_LIMIT_X: limit_x_r <= COORD_BITS'(cfg_data);
        ps2mp_pkg::REG_LIMIT_Y: limit_y_r <= COORD_BITS'(cfg_data);
        ps2mp_pkg::REG_START_X: start_x_r <= COORD_BITS'(cfg_data);
        ps2mp_pkg::REG_START_Y: start_y_r <= COORD_BITS'(cfg_data);
        default: begin
        end
      endcase
    end
  end

  ps2mp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_enable (in_tuser),
    .in_byte   (in_tdata),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  ps2mp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .valid    (q_valid),
    .pop_cmd  (pop_cmd)
  );

  ps2mp_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (q_valid),
    .cmd         (pop_cmd),
    .pop         (pop),
    .limit_x     (limit_x_r),
    .limit_y     (limit_y_r),
    .start_x     (start_x_r),
    .start_y     (start_y_r),
    .res_valid   (out_tvalid),
    .res_ready   (out_tready),
    .res_done    (res_done),
    .res_buttons (res_buttons),
    .res_move_x  (res_move_x),
    .res_move_y  (res_move_y),
    .res_pos_x   (res_pos_x),
    .res_pos_y   (res_pos_y)
  );

  assign out_tuser = res_done;
  assign out_tdata = OUT_BITS'({res_pos_y, res_pos_x, res_move_y, res_move_x, res_buttons});

`ifndef ASSERT_OFF
  // a completed packet always leaves the pointer inside its limits
  a_packet_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && res_done |-> res_pos_x <= limit_x_r && res_pos_y <= limit_y_r)
    else $error("pointer outside limits after packet");

  // an executed enable loads the start position
  a_enable_loads_start: assert property (@(posedge clk) disable iff (!rst_n)
    pop && pop_cmd.kind == ps2mp_pkg::CMD_ENABLE |=>
      res_pos_x == $past(start_x_r) && res_pos_y == $past(start_y_r) && !res_done)
    else $error("enable did not reload the pointer");

  // the front end never writes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("command queue overflow");

  // a command is only taken when the output register can take the result
  a_pop_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid && (!out_tvalid || out_tready))
    else $error("command executed without output room");
`endif

endmodule

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives mouse bytes and enable requests into ps2_mouse_packet_to_pointer and
// checks every result against a packet decoder and pointer tracker kept here.
// A directed burst covers the protocol corner cases. Random phases follow,
// each with its own limits and start position and one of four idle patterns.
// ----------------------------------------------------------------------------
module testbench;

  localparam int OUT_W       = 48;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 310;

  typedef enum logic {
    OP_BYTE   = 1'b0,
    OP_ENABLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_ACK,
    ST_HDR,
    ST_X,
    ST_Y
  } rx_state_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
  } mouse_req_t;

  typedef struct packed {
    logic                                     done;
    logic [ps2mp_pkg::BTN_BITS-1:0]           buttons;
    logic signed [ps2mp_pkg::MOVE_X_BITS-1:0] move_x;
    logic signed [ps2mp_pkg::MOVE_Y_BITS-1:0] move_y;
    logic [11:0]                              pos_x;
    logic [11:0]                              pos_y;
  } ptr_report_t;

  logic                                clk = 1'b0;
  logic                                rst_n = 1'b0;
  logic [7:0]                          in_tdata = '0;
  logic                                in_tuser = 1'b0;
  logic                                in_tvalid = 1'b0;
  logic                                in_tready;
  logic [OUT_W-1:0]                    out_tdata;
  logic                                out_tuser;
  logic                                out_tvalid;
  logic                                out_tready = 1'b0;
  logic                                cfg_valid = 1'b0;
  logic                                cfg_ready;
  logic [ps2mp_pkg::CFG_ADDR_BITS-1:0] cfg_addr = '0;
  logic [ps2mp_pkg::CFG_DATA_BITS-1:0] cfg_data = '0;

  // decoder and pointer state mirrored here
  rx_state_t                                rx_st;
  logic [7:0]                               hdr_byte;
  logic [7:0]                               x_byte;
  logic [11:0]                              ptr_x;
  logic [11:0]                              ptr_y;
  logic [ps2mp_pkg::BTN_BITS-1:0]           last_btn;
  logic signed [ps2mp_pkg::MOVE_X_BITS-1:0] last_mx;
  logic signed [ps2mp_pkg::MOVE_Y_BITS-1:0] last_my;
  logic [11:0]                              lim_x;
  logic [11:0]                              lim_y;
  logic [11:0]                              st_x;
  logic [11:0]                              st_y;

  mouse_req_t  pending_reqs[$];
  ptr_report_t expected_reports[$];
  int          tx_idle_pct = 0;
  int          rx_stall_pct = 0;
  int          mismatches = 0;
  int          cycle_count = 0;

  ps2_mouse_packet_to_pointer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  function automatic int clamp_coord(int pos, int delta, int lim);
    int v;
    v = pos + delta;
    if (v < 0) begin
      return 0;
    end
    if (v > lim) begin
      return lim;
    end
    return v;
  endfunction

  task automatic track_pointer(input mouse_req_t req, output ptr_report_t rep);
    int   mx;
    int   my;
    logic done;
    done = 1'b0;
    if (req.op == OP_ENABLE) begin
      rx_st = ST_ACK;
      ptr_x = st_x;
      ptr_y = st_y;
    end else begin
      case (rx_st)
        ST_ACK: begin
          if (req.data == ps2mp_pkg::ACK_BYTE) rx_st = ST_HDR;
        end
        ST_HDR: begin
          if ((req.data & ps2mp_pkg::HDR_MASK) == ps2mp_pkg::HDR_MATCH) begin
            hdr_byte = req.data;
            rx_st = ST_X;
          end
        end
        ST_X: begin
          x_byte = req.data;
          rx_st = ST_Y;
        end
        default: begin
          mx = x_byte;
          my = req.data;
          if (hdr_byte[ps2mp_pkg::HDR_XSIGN]) mx -= 256;
          if (hdr_byte[ps2mp_pkg::HDR_YSIGN]) my -= 256;
          // mouse y grows upward, screen y downward
          my = -my;
          last_btn = hdr_byte[ps2mp_pkg::BTN_BITS-1:0];
          last_mx = mx[ps2mp_pkg::MOVE_X_BITS-1:0];
          last_my = my[ps2mp_pkg::MOVE_Y_BITS-1:0];
          ptr_x = 12'(clamp_coord(ptr_x, mx, lim_x));
          ptr_y = 12'(clamp_coord(ptr_y, my, lim_y));
          rx_st = ST_HDR;
          done = 1'b1;
        end
      endcase
    end
    rep = '{done, last_btn, last_mx, last_my, ptr_x, ptr_y};
  endtask

  task automatic push_req(input op_t op, input logic [7:0] data);
    pending_reqs.push_back('{op, data});
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // called at a rising edge with the block idle
  task automatic write_regs(input logic [11:0] lx, input logic [11:0] ly,
                            input logic [11:0] sx, input logic [11:0] sy);
    logic [ps2mp_pkg::CFG_ADDR_BITS-1:0] addrs[4];
    logic [11:0]                         vals[4];
    addrs = '{ps2mp_pkg::REG_LIMIT_X, ps2mp_pkg::REG_LIMIT_Y,
              ps2mp_pkg::REG_START_X, ps2mp_pkg::REG_START_Y};
    vals = '{lx, ly, sx, sy};
    for (int i = 0; i < 4; i++) begin
      cfg_addr <= addrs[i];
      cfg_data <= vals[i];
      cfg_valid <= 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (addrs[i])
        ps2mp_pkg::REG_LIMIT_X: lim_x = vals[i];
        ps2mp_pkg::REG_LIMIT_Y: lim_y = vals[i];
        ps2mp_pkg::REG_START_X: st_x = vals[i];
        default:                st_y = vals[i];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(posedge clk) begin
    ptr_report_t rep;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_pointer(pending_reqs[0], rep);
        expected_reports.push_back(rep);
        void'(pending_reqs.pop_front());
      end
      if (!(in_tvalid && !in_tready)) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_tvalid <= 1'b1;
          in_tuser <= pending_reqs[0].op;
          in_tdata <= pending_reqs[0].data;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    ptr_report_t got;
    ptr_report_t want;
    out_tready <= ($urandom_range(99) >= rx_stall_pct);
    if (rst_n && out_tvalid && out_tready) begin
      got = '{out_tuser, out_tdata[2:0], out_tdata[11:3], out_tdata[21:12],
              out_tdata[33:22], out_tdata[45:34]};
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: %p", got);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected done=%0d btn=%0d mx=%0d my=%0d x=%0d y=%0d",
                     want.done, want.buttons, $signed(want.move_x), $signed(want.move_y),
                     want.pos_x, want.pos_y);
            $display("          got      done=%0d btn=%0d mx=%0d my=%0d x=%0d y=%0d",
                     got.done, got.buttons, $signed(got.move_x), $signed(got.move_y),
                     got.pos_x, got.pos_y);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int          count;
    int          r;
    logic [11:0] lx;
    logic [11:0] ly;
    logic [11:0] sx;
    logic [11:0] sy;

    rx_st = ST_ACK;
    hdr_byte = '0;
    x_byte = '0;
    ptr_x = 12'(ps2mp_pkg::RST_START_X);
    ptr_y = 12'(ps2mp_pkg::RST_START_Y);
    last_btn = '0;
    last_mx = '0;
    last_my = '0;
    lim_x = 12'(ps2mp_pkg::RST_LIMIT_X);
    lim_y = 12'(ps2mp_pkg::RST_LIMIT_Y);
    st_x = 12'(ps2mp_pkg::RST_START_X);
    st_y = 12'(ps2mp_pkg::RST_START_Y);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed burst under the reset configuration
    @(negedge clk);
    push_req(OP_BYTE, 8'h55);      // ignored while awaiting acknowledge
    push_req(OP_BYTE, 8'hFF);
    push_req(OP_BYTE, ps2mp_pkg::ACK_BYTE);
    push_req(OP_BYTE, 8'hC8);      // bad headers are dropped
    push_req(OP_BYTE, ps2mp_pkg::ACK_BYTE);
    push_req(OP_BYTE, 8'h3F);      // both signs, all buttons: most negative x
    push_req(OP_BYTE, 8'h00);
    push_req(OP_BYTE, 8'h00);
    push_req(OP_BYTE, 8'h08);      // largest positive x; y clamps at zero
    push_req(OP_BYTE, 8'hFF);
    push_req(OP_BYTE, 8'hFF);
    push_req(OP_BYTE, 8'h29);
    push_req(OP_BYTE, 8'h01);
    push_req(OP_BYTE, 8'hFF);
    push_req(OP_ENABLE, 8'hA5);
    push_req(OP_BYTE, 8'h08);
    push_req(OP_BYTE, ps2mp_pkg::ACK_BYTE);
    push_req(OP_BYTE, 8'h0A);
    push_req(OP_BYTE, 8'h10);
    push_req(OP_ENABLE, 8'hFF);    // enable in the middle of a packet
    push_req(OP_BYTE, ps2mp_pkg::ACK_BYTE);
    push_req(OP_BYTE, 8'h1B);
    push_req(OP_BYTE, 8'h80);
    push_req(OP_BYTE, 8'h7F);
    @(posedge clk);
    drain();

    for (int p = 0; p < 5; p++) begin
      case (p % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 51; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 51; end
        default: begin tx_idle_pct = 29; rx_stall_pct = 29; end
      endcase
      case (p)
        0: begin lx = 12'hFFF; ly = 12'hFFF; sx = 12'hFFF; sy = 12'hFFF; end
        1: begin lx = 12'h000; ly = 12'h000; sx = 12'h000; sy = 12'h000; end
        // start beyond the limits, clamped by the first packet
        2: begin lx = 12'd100; ly = 12'd50; sx = 12'hFFF; sy = 12'hFFF; end
        3: begin
          lx = 12'($urandom_range(4095));
          ly = 12'($urandom_range(4095));
          sx = 12'($urandom_range(4095));
          sy = 12'($urandom_range(4095));
        end
        default: begin
          lx = 12'(ps2mp_pkg::RST_LIMIT_X);
          ly = 12'(ps2mp_pkg::RST_LIMIT_Y);
          sx = 12'(ps2mp_pkg::RST_START_X);
          sy = 12'(ps2mp_pkg::RST_START_Y);
        end
      endcase
      write_regs(lx, ly, sx, sy);

      @(negedge clk);
      push_req(OP_ENABLE, 8'($urandom));
      push_req(OP_BYTE, ps2mp_pkg::ACK_BYTE);
      count = 0;
      while (count < PHASE_BYTES) begin
        r = $urandom_range(99);
        if (r < 8) begin
          push_req(OP_BYTE, 8'($urandom));
        end else if (r < 11) begin
          push_req(OP_ENABLE, 8'($urandom));
          repeat ($urandom_range(2)) push_req(OP_BYTE, 8'($urandom));
          push_req(OP_BYTE, ps2mp_pkg::ACK_BYTE);
        end else begin
          push_req(OP_BYTE, {2'b00, 2'($urandom), 1'b1, 3'($urandom)});
          push_req(OP_BYTE, 8'($urandom));
          push_req(OP_BYTE, 8'($urandom));
          count += 3;
        end
      end
      @(posedge clk);
      drain();
    end

    repeat (10) @(posedge clk);
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/ps2mp_pkg.sv
rtl/ps2mp_front.sv
rtl/ps2mp_fifo.sv
rtl/ps2mp_back.sv
rtl/ps2_mouse_packet_to_pointer.sv
tb/sv/testbench.sv
